// ----- rtl/core/spti_pkg.sv -----
// ----------------------------------------------------------------------------
// spti_pkg
// Shared types and constants of the sorted point table interpolator.
// ----------------------------------------------------------------------------
package spti_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int DATA_W        = 32;
   localparam int SUM_W         = 40;

   // Operation codes carried by req_opcode.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // What one cell hands to its right-hand neighbor.
   typedef struct packed {
      logic [DATA_W-1:0] energy;
      logic [DATA_W-1:0] sigma;
      logic              shift;   // this cell moves right on an insert
      logic              ge;      // this cell holds an energy >= the query
   } link_type;

   // The two points that bracket a query energy.
   typedef struct packed {
      logic [DATA_W-1:0] e_lo;
      logic [DATA_W-1:0] s_lo;
      logic [DATA_W-1:0] e_hi;
      logic [DATA_W-1:0] s_hi;
   } span_type;

endpackage

// ----- rtl/core/spti_cell.sv -----
// ----------------------------------------------------------------------------
// spti_cell
// One table slot: holds a point, shifts right on a sorted insert and flags
// itself when it is the first point at or above the query energy.
// ----------------------------------------------------------------------------
module spti_cell
   import spti_pkg::*;
(
   input  logic              clock,
   input  logic              ins_en,
   input  logic [DATA_W-1:0] ins_energy,
   input  logic [DATA_W-1:0] ins_sigma,
   input  logic [DATA_W-1:0] qry_energy,
   input  logic              occupied,
   input  link_type          left,
   output link_type          right,
   output span_type          span
);

   logic [DATA_W-1:0] energy_ff;
   logic [DATA_W-1:0] sigma_ff;

   always_comb begin
      right.energy = energy_ff;
      right.sigma  = sigma_ff;
      right.shift  = !occupied || (energy_ff > ins_energy);
      right.ge     = occupied && (energy_ff >= qry_energy);
      if (right.ge && !left.ge) begin
         span = '{e_lo: left.energy, s_lo: left.sigma, e_hi: energy_ff, s_hi: sigma_ff};
      end else begin
         span = '0;
      end
   end

   // Cells above the insert point take their neighbor's point; the first of
   // them (the boundary) takes the new point.
   always_ff @(posedge clock) begin
      if (ins_en) begin
         if (left.shift) begin
            energy_ff <= left.energy;
            sigma_ff  <= left.sigma;
         end else if (right.shift) begin
            energy_ff <= ins_energy;
            sigma_ff  <= ins_sigma;
         end
      end
   end

endmodule

// ----- rtl/core/spti_or_tree.sv -----
// ----------------------------------------------------------------------------
// spti_or_tree
// Registered binary OR tree that gathers the single flagged span of the row.
// ----------------------------------------------------------------------------
module spti_or_tree
   import spti_pkg::*;
#(
   parameter int LEAVES = DEPTH_DEFAULT,
   parameter int WIDTH  = $bits(span_type)
)
(
   input  logic             clock,
   input  logic [WIDTH-1:0] leaf [LEAVES],
   output logic [WIDTH-1:0] root
);

   localparam int LVLS = (LEAVES < 2) ? 1 : $clog2(LEAVES);
   localparam int P    = 1 << LVLS;

   logic [WIDTH-1:0] leaf_w  [P];
   logic [WIDTH-1:0] node_ff [1:P-1];

   genvar g;
   generate
      for (g = 0; g < P; g++) begin : g_leaf
         if (g < LEAVES) begin : g_real
            assign leaf_w[g] = leaf[g];
         end else begin : g_pad
            assign leaf_w[g] = '0;
         end
      end
      for (g = 1; g < P; g++) begin : g_node
         if (2 * g >= P) begin : g_bottom
            always_ff @(posedge clock) begin
               node_ff[g] <= leaf_w[2 * g - P] | leaf_w[2 * g + 1 - P];
            end
         end else begin : g_inner
            always_ff @(posedge clock) begin
               node_ff[g] <= node_ff[2 * g] | node_ff[2 * g + 1];
            end
         end
      end
   endgenerate

   assign root = node_ff[1];

endmodule

// ----- rtl/core/spti_divider.sv -----
// ----------------------------------------------------------------------------
// spti_divider
// Restoring divider, one quotient bit per cycle, for a 64-bit dividend whose
// quotient is known to fit in 32 bits.
// ----------------------------------------------------------------------------
module spti_divider
   import spti_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2*DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0]   divisor,
   output logic [DATA_W-1:0]   quotient,
   output logic                done
);

   localparam int STEP_W = $clog2(DATA_W);

   logic [DATA_W-1:0] rem_ff,  rem_in;
   logic [DATA_W-1:0] quo_ff,  quo_in;
   logic [DATA_W-1:0] div_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DATA_W:0]   trial;

   always_comb begin
      trial = {rem_ff, quo_ff[DATA_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = DATA_W'(trial - {1'b0, div_ff});
         quo_in = {quo_ff[DATA_W-2:0], 1'b1};
      end else begin
         rem_in = trial[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= dividend[2*DATA_W-1:DATA_W];
            quo_ff  <= dividend[DATA_W-1:0];
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= quo_in;
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(DATA_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

   done_not_busy_a: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");

endmodule

// ----- rtl/core/sorted_point_table_interpolator.sv -----
// ----------------------------------------------------------------------------
// sorted_point_table_interpolator
// Table of points kept sorted by energy in a row of cells, with linear
// interpolation of the cross-section between the bracketing points.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                      | Direction
//  --------+--------------------------------------------+----------
//  request | req_valid, req_stall, req_opcode,          | in
//          | req_point_energy, req_cross_section,       |
//          | req_production_rate                        |
//  result  | rsp_valid, rsp_stall, rsp_sigma_value, ... | out
//
// An insert or an out-of-range query completes at the accepting edge, where
// its result is registered. An in-range query passes in order through its
// acceptance, the registered OR tree that gathers the bracketing points and
// the multiply step; an exact match of a stored energy is answered there.
// Any other query then starts the divider and waits for the serial divide
// and the capture of its quotient; at the default depth the serial divide
// is the longest of these steps.
// One transaction is worked on at a time; a new request is taken once the
// previous result has left the output register.
// Reset is synchronous and empties the table; no clearing pass is needed,
// since only slots below the point count are ever read.
// ----------------------------------------------------------------------------
module sorted_point_table_interpolator
   import spti_pkg::*;
#(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic [DATA_W-1:0]                    req_point_energy,
   input  logic [DATA_W-1:0]                    req_cross_section,
   input  logic [DATA_W-1:0]                    req_production_rate,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [DATA_W-1:0]                    rsp_sigma_value,
   output logic                                 rsp_in_range,
   output logic                                 rsp_insert_rejected,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]     rsp_point_count,
   output logic [SUM_W-1:0]                     rsp_sigma_total,
   output logic [SUM_W-1:0]                     rsp_rate_total
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int LVLS   = (TABLE_DEPTH < 2) ? 1 : $clog2(TABLE_DEPTH);
   localparam int WAIT_W = $clog2(LVLS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MULT,
      ST_DIV_GO,
      ST_DIV_WAIT
   } state_type;

   state_type           state_ff;
   logic [WAIT_W-1:0]   wait_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [DATA_W-1:0]   min_ff;
   logic [DATA_W-1:0]   max_ff;
   logic [SUM_W-1:0]    sigma_sum_ff, sigma_sum_in;
   logic [SUM_W-1:0]    rate_sum_ff,  rate_sum_in;
   logic [DATA_W-1:0]   qry_ff;

   // Values taken from the bracketing points, held for the divide step.
   logic [DATA_W-1:0]   s_lo_ff;
   logic                descend_ff;
   logic [2*DATA_W-1:0] mag_ff;
   logic [DATA_W-1:0]   de_ff;

   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   sigma_ff;
   logic                in_range_ff;
   logic                rejected_ff;

   logic                accept;
   logic                full;
   logic                ins_en;
   logic                out_range;
   logic                div_start;
   logic                div_done;
   logic [DATA_W-1:0]   div_quo;
   logic [DATA_W-1:0]   diff;
   span_type            found;

   link_type            link  [TABLE_DEPTH+1];
   logic [$bits(span_type)-1:0] spans [TABLE_DEPTH];
   logic [$bits(span_type)-1:0] root;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign ins_en    = accept && (req_opcode == OP_INSERT) && !full;
   assign out_range = (req_point_energy < min_ff) || (req_point_energy > max_ff);

   // Totals saturate at the top of their range instead of wrapping.
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                input logic [DATA_W-1:0] v);
      logic [SUM_W:0] s;
      s = {1'b0, acc} + (SUM_W+1)'(v);
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
   endfunction

   assign sigma_sum_in = sat_add(sigma_sum_ff, req_cross_section);
   assign rate_sum_in  = sat_add(rate_sum_ff, req_production_rate);

   // The row of cells. The left end feeds a cell that never shifts and never
   // counts as at or above the query, so the first cell sees no neighbor.
   assign link[0] = '0;

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         span_type cell_span;
         spti_cell u_cell (
            .clock      (clock),
            .ins_en     (ins_en),
            .ins_energy (req_point_energy),
            .ins_sigma  (req_cross_section),
            .qry_energy (qry_ff),
            .occupied   (count_ff > CNT_W'(g)),
            .left       (link[g]),
            .right      (link[g+1]),
            .span       (cell_span)
         );
         assign spans[g] = cell_span;
      end
   endgenerate

   spti_or_tree #(
      .LEAVES (TABLE_DEPTH),
      .WIDTH  ($bits(span_type))
   ) u_tree (
      .clock (clock),
      .leaf  (spans),
      .root  (root)
   );

   assign found = span_type'(root);
   assign diff  = (found.s_hi >= found.s_lo) ? (found.s_hi - found.s_lo)
                                             : (found.s_lo - found.s_hi);

   assign div_start = (state_ff == ST_DIV_GO);

   spti_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff),
      .divisor  (de_ff),
      .quotient (div_quo),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= '0;
         count_ff     <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         sigma_sum_ff <= '0;
         rate_sum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  qry_ff      <= req_point_energy;
                  sigma_ff    <= '0;
                  in_range_ff <= 1'b0;
                  rejected_ff <= 1'b0;
                  if (req_opcode == OP_INSERT) begin
                     rsp_valid_ff <= 1'b1;
                     if (full) begin
                        rejected_ff <= 1'b1;
                     end else begin
                        count_ff     <= count_ff + 1'b1;
                        sigma_sum_ff <= sigma_sum_in;
                        rate_sum_ff  <= rate_sum_in;
                        if (req_point_energy < min_ff) min_ff <= req_point_energy;
                        if (req_point_energy > max_ff) max_ff <= req_point_energy;
                     end
                  end else if (out_range) begin
                     // An empty table has min above max, so it lands here too.
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     in_range_ff <= 1'b1;
                     wait_ff     <= '0;
                     state_ff    <= ST_SEARCH;
                  end
               end
            end
            ST_SEARCH: begin
               // The leaves follow the query register combinationally, then each level of
               // the tree adds a register.
               wait_ff <= wait_ff + 1'b1;
               if (wait_ff == WAIT_W'(LVLS - 1)) begin
                  state_ff <= ST_MULT;
               end
            end
            ST_MULT: begin
               if (found.e_hi == qry_ff) begin
                  sigma_ff     <= found.s_hi;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  s_lo_ff    <= found.s_lo;
                  descend_ff <= (found.s_hi < found.s_lo);
                  mag_ff     <= (2*DATA_W)'(diff) * (2*DATA_W)'(qry_ff - found.e_lo);
                  de_ff      <= found.e_hi - found.e_lo;
                  state_ff   <= ST_DIV_GO;
               end
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  sigma_ff     <= descend_ff ? (s_lo_ff - div_quo) : (s_lo_ff + div_quo);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sigma_value     = sigma_ff;
   assign rsp_in_range        = in_range_ff;
   assign rsp_insert_rejected = rejected_ff;
   assign rsp_point_count     = count_ff;
   assign rsp_sigma_total     = sigma_sum_ff;
   assign rsp_rate_total      = rate_sum_ff;

   count_bound_a: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH)) else $error("point count beyond table depth");

   insert_counts_a: assert property (@(posedge clock) disable iff (reset)
      ins_en |=> count_ff == $past(count_ff) + 1'b1) else $error("insert not counted");

   busy_stalls_a: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall && !rsp_valid_ff)
      else $error("request taken or result shown while a query is at work");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the sorted point table interpolator. Named test tasks drive
// inserts and queries through the request channel. A behavioral table model
// predicts every result, and one checker process compares each result
// transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import spti_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = 256;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int WATCHDOG   = 20000;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // One predicted result transaction.
   typedef struct {
      logic [DATA_W-1:0] sigma;
      logic              in_range;
      logic              rejected;
      logic [CNT_W-1:0]  count;
      logic [SUM_W-1:0]  sigma_total;
      logic [SUM_W-1:0]  rate_total;
   } interp_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_opcode;
   logic [DATA_W-1:0] req_point_energy;
   logic [DATA_W-1:0] req_cross_section;
   logic [DATA_W-1:0] req_production_rate;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [DATA_W-1:0] rsp_sigma_value;
   logic              rsp_in_range;
   logic              rsp_insert_rejected;
   logic [CNT_W-1:0]  rsp_point_count;
   logic [SUM_W-1:0]  rsp_sigma_total;
   logic [SUM_W-1:0]  rsp_rate_total;

   sorted_point_table_interpolator #(.TABLE_DEPTH(DEPTH)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_point_energy    (req_point_energy),
      .req_cross_section   (req_cross_section),
      .req_production_rate (req_production_rate),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sigma_value     (rsp_sigma_value),
      .rsp_in_range        (rsp_in_range),
      .rsp_insert_rejected (rsp_insert_rejected),
      .rsp_point_count     (rsp_point_count),
      .rsp_sigma_total     (rsp_sigma_total),
      .rsp_rate_total      (rsp_rate_total)
   );

   // Clock with a 12 ns period.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Model state of the point table. Only entries below point_total are read.
   logic [DATA_W-1:0] model_energy [DEPTH];
   logic [DATA_W-1:0] model_sigma  [DEPTH];
   int                point_total;
   logic [DATA_W-1:0] lowest_energy;
   logic [DATA_W-1:0] highest_energy;
   logic [SUM_W-1:0]  sigma_sum;
   logic [SUM_W-1:0]  rate_sum;

   // Predictions waiting for their result, kept in a small ring.
   interp_result_type expect_ring [16];
   int                ring_wr;
   int                ring_rd;
   int                error_count;
   int                send_idle_pct;
   int                recv_stall_pct;
   int                quiet_cycles;

   // Adds to a 40-bit total, saturating at all ones instead of wrapping.
   function automatic logic [SUM_W-1:0] add_saturated(logic [SUM_W-1:0] acc,
                                                      logic [DATA_W-1:0] v);
      logic [SUM_W:0] s;
      s = {1'b0, acc} + (SUM_W+1)'(v);
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   // Linear interpolation at energy e over the sorted model table. The caller
   // has already checked that e lies within the stored range.
   function automatic logic [DATA_W-1:0] interpolate_sigma(logic [DATA_W-1:0] e);
      logic [DATA_W-1:0] e1, s1, e2, s2;
      logic [63:0]       mag, quo;
      bit                found_hi;
      e1 = '0; s1 = '0; e2 = '0; s2 = '0;
      found_hi = 0;
      for (int i = 0; i < point_total; i++) begin
         if (model_energy[i] == e) return model_sigma[i];
         if (model_energy[i] < e) begin
            e1 = model_energy[i];
            s1 = model_sigma[i];
         end else begin
            e2 = model_energy[i];
            s2 = model_sigma[i];
            found_hi = 1;
            break;
         end
      end
      if (!found_hi || e2 <= e1) return s1;
      if (s2 >= s1) begin
         mag = 64'(s2 - s1) * 64'(e - e1);
         quo = mag / 64'(e2 - e1);
         return s1 + quo[DATA_W-1:0];
      end
      mag = 64'(s1 - s2) * 64'(e - e1);
      quo = mag / 64'(e2 - e1);
      return s1 - quo[DATA_W-1:0];
   endfunction

   // Applies one accepted request to the model and returns its result.
   function automatic interp_result_type predict_result(logic op, logic [DATA_W-1:0] e,
                                                        logic [DATA_W-1:0] s,
                                                        logic [DATA_W-1:0] r);
      interp_result_type res;
      int pos;
      res = '{default: '0};
      if (op == OP_INSERT) begin
         if (point_total >= DEPTH) begin
            res.rejected = 1'b1;
         end else begin
            // A new point goes after every stored point of equal energy.
            pos = 0;
            while (pos < point_total && model_energy[pos] <= e) pos++;
            for (int i = point_total; i > pos; i--) begin
               model_energy[i] = model_energy[i-1];
               model_sigma[i]  = model_sigma[i-1];
            end
            model_energy[pos] = e;
            model_sigma[pos]  = s;
            point_total++;
            if (e < lowest_energy)  lowest_energy  = e;
            if (e > highest_energy) highest_energy = e;
            sigma_sum = add_saturated(sigma_sum, s);
            rate_sum  = add_saturated(rate_sum, r);
         end
      end else if (point_total != 0 && e >= lowest_energy && e <= highest_energy) begin
         res.in_range = 1'b1;
         res.sigma    = interpolate_sigma(e);
      end
      res.count       = CNT_W'(point_total);
      res.sigma_total = sigma_sum;
      res.rate_total  = rate_sum;
      return res;
   endfunction

   // Sends one request transaction and records its prediction once accepted.
   // Valid stays high across back-to-back items; it only drops on an idle gap.
   task automatic send_request(logic op, logic [DATA_W-1:0] e,
                               logic [DATA_W-1:0] s, logic [DATA_W-1:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_opcode          <= op;
      req_point_energy    <= e;
      req_cross_section   <= s;
      req_production_rate <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expect_ring[ring_wr[3:0]] = predict_result(op, e, s, r);
      ring_wr++;
   endtask

   // Releases valid after the last transaction of a phase.
   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Result checker. Samples at the rising edge, so values are the ones that
   // were stable before the edge.
   always @(posedge clock) begin
      interp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ring_rd == ring_wr) begin
            $error("result transaction with no prediction waiting");
            error_count++;
         end else begin
            want = expect_ring[ring_rd[3:0]];
            ring_rd++;
            if (rsp_sigma_value !== want.sigma) begin
               $error("sigma_value: expected %0h, got %0h", want.sigma, rsp_sigma_value);
               error_count++;
            end
            if (rsp_in_range !== want.in_range) begin
               $error("in_range: expected %0b, got %0b", want.in_range, rsp_in_range);
               error_count++;
            end
            if (rsp_insert_rejected !== want.rejected) begin
               $error("insert_rejected: expected %0b, got %0b", want.rejected,
                      rsp_insert_rejected);
               error_count++;
            end
            if (rsp_point_count !== want.count) begin
               $error("point_count: expected %0d, got %0d", want.count, rsp_point_count);
               error_count++;
            end
            if (rsp_sigma_total !== want.sigma_total) begin
               $error("sigma_total: expected %0h, got %0h", want.sigma_total,
                      rsp_sigma_total);
               error_count++;
            end
            if (rsp_rate_total !== want.rate_total) begin
               $error("rate_total: expected %0h, got %0h", want.rate_total,
                      rsp_rate_total);
               error_count++;
            end
         end
      end
   end

   // Random stall on the result side, redrawn every cycle.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else       rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Watchdog: counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("sorted_point_table_interpolator test failed");
            $finish;
         end
      end
   end

   // Picks an energy that is often near or equal to a stored one, so that
   // exact matches and narrow spans are common.
   function automatic logic [DATA_W-1:0] pick_energy();
      int k;
      k = $urandom_range(9);
      if (point_total != 0 && k < 3)
         return model_energy[$urandom_range(point_total - 1)];
      if (point_total != 0 && k < 5)
         return model_energy[$urandom_range(point_total - 1)] + $urandom_range(3) - 1;
      if (k < 8)
         return $urandom_range(32'h0040_0000);
      return $urandom;
   endfunction

   // Empty table: every query is out of range, both extremes included.
   task automatic test_empty_table();
      send_request(OP_QUERY, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_QUERY, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send_request(OP_QUERY, 32'h0001_0000, 32'h0, 32'h0);
   endtask

   // Directed inserts and queries: exact match, duplicate energies, rising
   // and falling interpolation, out-of-range on both sides, field extremes.
   task automatic test_directed_points();
      send_request(OP_INSERT, 32'h0010_0000, 32'h0002_0000, 32'h0000_0001);
      send_request(OP_QUERY,  32'h0010_0000, 32'h0, 32'h0);
      send_request(OP_QUERY,  32'h000F_FFFF, 32'h0, 32'h0);
      send_request(OP_INSERT, 32'h0030_0000, 32'h0008_0000, 32'hFFFF_FFFF);
      send_request(OP_QUERY,  32'h0020_0000, 32'h0, 32'h0);
      send_request(OP_QUERY,  32'h0012_3457, 32'h0, 32'h0);
      send_request(OP_INSERT, 32'h0050_0000, 32'h0000_0100, 32'h0000_0000);
      send_request(OP_QUERY,  32'h0041_2345, 32'h0, 32'h0);
      send_request(OP_QUERY,  32'h0050_0001, 32'h0, 32'h0);
      // Same energy twice: the earlier point answers an exact match.
      send_request(OP_INSERT, 32'h0030_0000, 32'h1234_5678, 32'h0000_0002);
      send_request(OP_QUERY,  32'h0030_0000, 32'h0, 32'h0);
      send_request(OP_QUERY,  32'h0040_0000, 32'h0, 32'h0);
      // Energy and value extremes.
      send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_5555);
      send_request(OP_QUERY,  32'h0000_0000, 32'h0, 32'h0);
      send_request(OP_QUERY,  32'hFFFF_FFFF, 32'h0, 32'h0);
      send_request(OP_QUERY,  32'h8000_0000, 32'h0, 32'h0);
      send_request(OP_QUERY,  32'h0000_0001, 32'h0, 32'h0);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_AAAA);
      send_request(OP_QUERY,  32'hFFFF_FFFE, 32'h0, 32'h0);
   endtask

   // Random mix with queries dominating, as in normal use.
   task automatic test_random_mix(int n);
      logic op;
      for (int i = 0; i < n; i++) begin
         op = ($urandom_range(99) < 25) ? OP_INSERT : OP_QUERY;
         send_request(op, pick_energy(), $urandom, $urandom);
      end
   endtask

   // Fills the table with large values, then drives inserts into a full table
   // and queries against the full table.
   task automatic test_fill_and_reject();
      while (point_total < DEPTH)
         send_request(OP_INSERT, pick_energy(), $urandom | 32'hF000_0000,
                      $urandom | 32'hF000_0000);
      for (int i = 0; i < 8; i++)
         send_request(OP_INSERT, $urandom, $urandom, $urandom);
      test_random_mix(40);
   endtask

   initial begin
      error_count         = 0;
      ring_wr             = 0;
      ring_rd             = 0;
      send_idle_pct       = 21;
      recv_stall_pct      = 68;
      quiet_cycles        = 0;
      point_total         = 0;
      lowest_energy       = '1;
      highest_energy      = '0;
      sigma_sum           = '0;
      rate_sum            = '0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_opcode          = OP_INSERT;
      req_point_energy    = '0;
      req_cross_section   = '0;
      req_production_rate = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_directed_points();
      test_random_mix(120);
      stop_sending();
      // Swap the idle and stall rates: the sender now idles often, the receiver stalls rarely.
      send_idle_pct  = 68;
      recv_stall_pct = 21;
      test_random_mix(100);
      stop_sending();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_mix(40);
      test_fill_and_reject();
      stop_sending();

      while (ring_rd != ring_wr) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("sorted_point_table_interpolator test passed");
      else
         $display("sorted_point_table_interpolator test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/spti_pkg.sv
rtl/core/spti_cell.sv
rtl/core/spti_or_tree.sv
rtl/core/spti_divider.sv
rtl/core/sorted_point_table_interpolator.sv
sim/tb_top.sv
